// ----- src/cwsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cwsd_pkg;

  localparam int MAX_WORKERS = 8;
  localparam int MAX_CHUNKS  = 1024;
  localparam int WK_W        = $clog2(MAX_WORKERS);
  localparam int CNT_W       = 11;
  localparam int ROW_W       = 20;
  localparam int CR_W        = 16;
  localparam int WC_W        = 4;
  localparam int NUM_W       = 21;
  localparam logic [CR_W-1:0] CHUNK_ROWS_RESET = 16'd500;
  localparam logic [CNT_W-1:0] COUNT_LIMIT     = 11'd2047;

  // item kinds
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;
  localparam logic [1:0] OP_BAD   = 2'd3;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RETRY = 2'd1;
  localparam logic [1:0] ST_ALL   = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_CHUNK = 2'd1;
  localparam logic [1:0] REG_WK    = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [WK_W-1:0] worker;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] rows;
    logic [CR_W-1:0]  chunk;
    logic [WC_W-1:0]  workers;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CR_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- src/cwsd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface cwsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] worker;

  modport source (output valid, mode, worker, input ready);
  modport sink (input valid, mode, worker, output ready);
endinterface
`default_nettype wire

// ----- src/cwsd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface cwsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] row_begin;
  logic [19:0] row_end;
  logic        stolen;
  logic [2:0]  source_worker;
  logic        done_all;

  modport source (output valid, status, row_begin, row_end, stolen, source_worker, done_all,
                  input ready);
  modport sink (input valid, status, row_begin, row_end, stolen, source_worker, done_all,
                output ready);
endinterface
`default_nettype wire

// ----- src/cwsd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cwsd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  cwsd_in_if.sink            in_ch,
  output cwsd_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop
);

  cwsd_pkg::cmd_t fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cwsd_pkg::cmd_t in_cmd;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = fifo_r[rd_ptr_r];

  always_comb begin
    in_cmd.worker = in_ch.worker;
    case (in_ch.mode)
      cwsd_pkg::OP_START: in_cmd.op = cwsd_pkg::OP_START;
      cwsd_pkg::OP_REQ:   in_cmd.op = cwsd_pkg::OP_REQ;
      cwsd_pkg::OP_DONE:  in_cmd.op = cwsd_pkg::OP_DONE;
      default:            in_cmd.op = cwsd_pkg::OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !cmd_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && cmd_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- src/cwsd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cwsd_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cwsd_pkg::div_req_t req,
  output cwsd_pkg::div_rsp_t  rsp
);

  localparam int NW = cwsd_pkg::NUM_W;
  localparam int DW = cwsd_pkg::CR_W;

  logic          busy_r;
  logic [4:0]    cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          qbit;

  // restoring division, quotient bits shift into num_r
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], qbit};
      rem_r <= qbit ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/cwsd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cwsd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cwsd_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire cwsd_pkg::cfg_t cfg,
  output cwsd_pkg::div_req_t  div_req,
  input  wire cwsd_pkg::div_rsp_t div_rsp,
  cwsd_out_if.source          out_ch
);

  localparam int NWK = cwsd_pkg::MAX_WORKERS;
  localparam int WW  = cwsd_pkg::WK_W;
  localparam int CW  = cwsd_pkg::CNT_W;
  localparam int RW  = cwsd_pkg::ROW_W;
  localparam int CRW = cwsd_pkg::CR_W;
  localparam int PW  = CW + CRW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DTOT  = 3'd1;
  localparam logic [2:0] S_DPER  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_TAIL0 = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]           state_r;
  logic [RW-1:0]        lat_rows_r;
  logic [CRW-1:0]       lat_chunk_r;
  logic [cwsd_pkg::WC_W-1:0] lat_wk_r;
  logic [CW-1:0]        total_r, per_r, fin_r, acc_r, base_end_r, idx_r;
  logic                 done_r;
  logic [CW-1:0]        head_r [NWK];
  logic [CW-1:0]        tail_r [NWK];
  logic [CW-1:0]        base_r [NWK];
  logic [WW-1:0]        fill_w_r, src_r;
  logic                 stolen_r;
  logic [PW-1:0]        prod_r;

  logic                 out_valid_r, stolen_o_r, done_all_o_r;
  logic [1:0]           status_o_r;
  logic [RW-1:0]        begin_o_r, end_o_r;
  logic [WW-1:0]        src_o_r;

  logic [CRW-1:0]       cr_eff;
  logic [cwsd_pkg::WC_W-1:0] wc_eff;
  logic                 own_ok, found, hit, is_start, tot_ok;
  logic [WW-1:0]        steal_src, src_sel;
  logic [CW-1:0]        h_sel, idx_calc, left, fill_cnt, fin_nxt;
  logic [PW:0]          e_full;
  logic [RW-1:0]        e_cl;

  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid && !out_valid_r;
  assign is_start = cmd_pop && (cmd.op == cwsd_pkg::OP_START);
  assign tot_ok   = (div_rsp.quo <= cwsd_pkg::NUM_W'(cwsd_pkg::MAX_CHUNKS));

  assign cr_eff = (cfg.chunk == '0) ? CRW'(1) : cfg.chunk;
  always_comb begin
    if (cfg.workers == '0) wc_eff = 4'd1;
    else if (cfg.workers > 4'(NWK)) wc_eff = 4'(NWK);
    else wc_eff = cfg.workers;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = cwsd_pkg::NUM_W'(cfg.rows) + cwsd_pkg::NUM_W'(cr_eff) - 21'd1;
    div_req.den   = cr_eff;
    if (is_start) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DTOT) begin
      div_req.start = div_rsp.done && tot_ok;
      div_req.num   = {{(cwsd_pkg::NUM_W-CW){1'b0}}, div_rsp.quo[CW-1:0]};
      div_req.den   = CRW'(lat_wk_r);
    end
  end

  // own queue first, else lowest other non-empty queue
  always_comb begin
    own_ok = ({1'b0, cmd.worker} < lat_wk_r) && (head_r[cmd.worker] < tail_r[cmd.worker]);
    found = 1'b0;
    steal_src = '0;
    for (int w = 0; w < NWK; w++) begin
      if (!found && (WW'(w) != cmd.worker) && (head_r[w] < tail_r[w])) begin
        found = 1'b1;
        steal_src = WW'(w);
      end
    end
    hit     = own_ok || found;
    src_sel = own_ok ? cmd.worker : steal_src;
    h_sel   = head_r[src_sel];
    // queue 0 holds its own run followed by the leftover chunks
    if ((src_sel == '0) && (h_sel >= per_r)) idx_calc = base_end_r + h_sel - per_r;
    else idx_calc = base_r[src_sel] + h_sel;
  end

  assign left     = (total_r > acc_r) ? (total_r - acc_r) : '0;
  assign fill_cnt = (left < per_r) ? left : per_r;
  assign fin_nxt  = (fin_r < cwsd_pkg::COUNT_LIMIT) ? (fin_r + CW'(1)) : fin_r;
  assign e_full   = {1'b0, prod_r} + (PW+1)'(lat_chunk_r);
  assign e_cl     = (e_full > (PW+1)'(lat_rows_r)) ? lat_rows_r : e_full[RW-1:0];

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == cwsd_pkg::OP_REQ && hit) begin
      idx_r    <= idx_calc;
      src_r    <= src_sel;
      stolen_r <= (src_sel != cmd.worker);
    end
    if (state_r == S_MUL) prod_r <= PW'(idx_r) * PW'(lat_chunk_r);
    if (state_r == S_FILL) base_r[fill_w_r] <= acc_r;
    if (state_r == S_TAIL0) base_end_r <= acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lat_rows_r  <= '0;
      lat_chunk_r <= cwsd_pkg::CHUNK_ROWS_RESET;
      lat_wk_r    <= 4'd1;
      total_r     <= '0;
      per_r       <= CW'(1);
      fin_r       <= '0;
      acc_r       <= '0;
      done_r      <= 1'b0;
      fill_w_r    <= '0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < NWK; w++) begin
        head_r[w] <= '0;
        tail_r[w] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              cwsd_pkg::OP_START: begin
                lat_rows_r  <= cfg.rows;
                lat_chunk_r <= cr_eff;
                lat_wk_r    <= wc_eff;
                fin_r       <= '0;
                for (int w = 0; w < NWK; w++) begin
                  head_r[w] <= '0;
                  tail_r[w] <= '0;
                end
                state_r <= S_DTOT;
              end
              cwsd_pkg::OP_REQ: begin
                if (hit) begin
                  head_r[src_sel] <= h_sel + CW'(1);
                  state_r <= S_MUL;
                end else begin
                  out_valid_r  <= 1'b1;
                  status_o_r   <= (fin_r >= total_r) ? cwsd_pkg::ST_ALL : cwsd_pkg::ST_RETRY;
                  begin_o_r    <= '0;
                  end_o_r      <= '0;
                  stolen_o_r   <= 1'b0;
                  src_o_r      <= '0;
                  done_all_o_r <= done_r;
                end
              end
              cwsd_pkg::OP_DONE: begin
                fin_r <= fin_nxt;
                if (fin_nxt >= total_r) done_r <= 1'b1;
                out_valid_r  <= 1'b1;
                status_o_r   <= cwsd_pkg::ST_OK;
                begin_o_r    <= '0;
                end_o_r      <= '0;
                stolen_o_r   <= 1'b0;
                src_o_r      <= '0;
                done_all_o_r <= done_r || (fin_nxt >= total_r);
              end
              default: begin
                out_valid_r  <= 1'b1;
                status_o_r   <= cwsd_pkg::ST_RETRY;
                begin_o_r    <= '0;
                end_o_r      <= '0;
                stolen_o_r   <= 1'b0;
                src_o_r      <= '0;
                done_all_o_r <= done_r;
              end
            endcase
          end
        end
        S_DTOT: begin
          if (div_rsp.done) begin
            if (tot_ok) begin
              total_r <= div_rsp.quo[CW-1:0];
              state_r <= S_DPER;
            end else begin
              total_r      <= '0;
              done_r       <= 1'b1;
              out_valid_r  <= 1'b1;
              status_o_r   <= cwsd_pkg::ST_OVER;
              begin_o_r    <= '0;
              end_o_r      <= '0;
              stolen_o_r   <= 1'b0;
              src_o_r      <= '0;
              done_all_o_r <= 1'b1;
              state_r      <= S_IDLE;
            end
          end
        end
        S_DPER: begin
          if (div_rsp.done) begin
            per_r    <= (div_rsp.quo == '0) ? CW'(1) : div_rsp.quo[CW-1:0];
            acc_r    <= '0;
            fill_w_r <= '0;
            state_r  <= S_FILL;
          end
        end
        S_FILL: begin
          if ({1'b0, fill_w_r} < lat_wk_r) begin
            tail_r[fill_w_r] <= fill_cnt;
            acc_r <= acc_r + per_r;
          end
          if (fill_w_r == WW'(NWK - 1)) state_r <= S_TAIL0;
          else fill_w_r <= fill_w_r + WW'(1);
        end
        S_TAIL0: begin
          tail_r[0]    <= tail_r[0] + left;
          done_r       <= (total_r == '0);
          out_valid_r  <= 1'b1;
          status_o_r   <= cwsd_pkg::ST_OK;
          begin_o_r    <= '0;
          end_o_r      <= '0;
          stolen_o_r   <= 1'b0;
          src_o_r      <= '0;
          done_all_o_r <= (total_r == '0);
          state_r      <= S_IDLE;
        end
        S_MUL: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r  <= 1'b1;
          status_o_r   <= cwsd_pkg::ST_OK;
          begin_o_r    <= prod_r[RW-1:0];
          end_o_r      <= e_cl;
          stolen_o_r   <= stolen_r;
          src_o_r      <= src_r;
          done_all_o_r <= done_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_o_r;
  assign out_ch.row_begin     = begin_o_r;
  assign out_ch.row_end       = end_o_r;
  assign out_ch.stolen        = stolen_o_r;
  assign out_ch.source_worker = src_o_r;
  assign out_ch.done_all      = done_all_o_r;

endmodule
`default_nettype wire

// ----- src/work_stealing_chunk_dispatcher.sv -----
// start item: two 21-step serial divisions, then queue setup at one worker per cycle;
//   one item at a time in the back end
// request: a grant goes through an index multiply (S_MUL) and an end clamp (S_FIN)
// completion report, unknown mode: no extra state; 2-deep queue takes items while the back works
// reset: synchronous active-low, clears queues, counters and config to its reset values
`timescale 1ns / 1ps
`default_nettype none
module work_stealing_chunk_dispatcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cwsd_in_if.sink          in_ch,
  cwsd_out_if.source       out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);

  cwsd_pkg::cfg_t     cfg_r;
  cwsd_pkg::cmd_t     cmd;
  logic               cmd_valid;
  logic               cmd_pop;
  cwsd_pkg::div_req_t div_req;
  cwsd_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows    <= '0;
      cfg_r.chunk   <= cwsd_pkg::CHUNK_ROWS_RESET;
      cfg_r.workers <= 4'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cwsd_pkg::REG_ROWS:  cfg_r.rows    <= cfg_wdata;
        cwsd_pkg::REG_CHUNK: cfg_r.chunk   <= cfg_wdata[15:0];
        cwsd_pkg::REG_WK:    cfg_r.workers <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  cwsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  cwsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cwsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
